// ===== design/l3h_pkg.sv =====
`timescale 1ns / 1ps

package l3h_pkg;

  localparam int unsigned LEN_W      = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned BLOCK_SIZE = 12;
  localparam int unsigned BLOCK_W    = BLOCK_SIZE * BYTE_W;
  localparam int unsigned FILL_W     = 4;
  localparam int unsigned STEP_W     = 3;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned FIFO_CW    = FIFO_AW + 1;

  localparam logic [WORD_W-1:0] SEED_CONST = 32'hDEADBEEF;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  localparam logic [STEP_W-1:0] MIX_LAST = 3'd5;
  localparam logic [STEP_W-1:0] FIN_LAST = 3'd6;

  typedef enum logic [1:0] {
    OP_SEED,
    OP_MIX,
    OP_FINAL,
    OP_EMPTY
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX,
    ST_FIN
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] w0;
    logic [WORD_W-1:0] w1;
    logic [WORD_W-1:0] w2;
  } op_entry_t;

  typedef struct packed {
    logic      valid;
    op_entry_t entry;
  } push_t;

  typedef struct packed {
    logic      empty;
    op_entry_t head;
  } fifo_stat_t;

  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
  } lanes_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                             input int unsigned k);
    return (x << k) | (x >> (WORD_W - k));
  endfunction

  // One line of the mix: a subtract and xor on one lane, an add on another.
  function automatic lanes_t mix_step(input lanes_t l, input logic [STEP_W-1:0] step);
    lanes_t r;
    r = l;
    case (step)
      3'd0: begin
        r.a = (l.a - l.c) ^ rotl(l.c, 4);
        r.c = l.c + l.b;
      end
      3'd1: begin
        r.b = (l.b - l.a) ^ rotl(l.a, 6);
        r.a = l.a + l.c;
      end
      3'd2: begin
        r.c = (l.c - l.b) ^ rotl(l.b, 8);
        r.b = l.b + l.a;
      end
      3'd3: begin
        r.a = (l.a - l.c) ^ rotl(l.c, 16);
        r.c = l.c + l.b;
      end
      3'd4: begin
        r.b = (l.b - l.a) ^ rotl(l.a, 19);
        r.a = l.a + l.c;
      end
      3'd5: begin
        r.c = (l.c - l.b) ^ rotl(l.b, 4);
        r.b = l.b + l.a;
      end
      default: r = l;
    endcase
    return r;
  endfunction

  // One line of the final mix: an xor then a subtract on one lane.
  function automatic lanes_t fin_step(input lanes_t l, input logic [STEP_W-1:0] step);
    lanes_t r;
    r = l;
    case (step)
      3'd0: r.c = (l.c ^ l.b) - rotl(l.b, 14);
      3'd1: r.a = (l.a ^ l.c) - rotl(l.c, 11);
      3'd2: r.b = (l.b ^ l.a) - rotl(l.a, 25);
      3'd3: r.c = (l.c ^ l.b) - rotl(l.b, 16);
      3'd4: r.a = (l.a ^ l.c) - rotl(l.c, 4);
      3'd5: r.b = (l.b ^ l.a) - rotl(l.a, 14);
      3'd6: r.c = (l.c ^ l.b) - rotl(l.b, 24);
      default: r = l;
    endcase
    return r;
  endfunction

endpackage

// ===== design/l3h_front.sv =====
`timescale 1ns / 1ps

module l3h_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_cmd,
  input  logic [l3h_pkg::LEN_W-1:0]  in_msg_length,
  input  logic [l3h_pkg::BYTE_W-1:0] in_data_byte,
  input  logic                       fifo_full,
  output l3h_pkg::push_t             push
);

  logic [l3h_pkg::BLOCK_W-1:0] block_r, block_nxt;
  logic [l3h_pkg::FILL_W-1:0]  fill_r, fill_nxt;
  logic [l3h_pkg::LEN_W-1:0]   left_r, left_nxt;
  logic [l3h_pkg::BLOCK_W-1:0] block_new;
  logic                        accept;
  logic                        byte_used;
  logic                        last_byte;
  logic                        block_full;

  assign in_stall   = fifo_full;
  assign accept     = in_valid && !fifo_full;
  assign byte_used  = accept && (in_cmd == l3h_pkg::CMD_DATA) && (left_r != '0);
  assign last_byte  = (left_r == l3h_pkg::LEN_W'(1));
  assign block_full = (fill_r == l3h_pkg::FILL_W'(l3h_pkg::BLOCK_SIZE - 1));

  always_comb begin
    block_new = block_r;
    for (int i = 0; i < l3h_pkg::BLOCK_SIZE; i++) begin
      if (fill_r == l3h_pkg::FILL_W'(i)) begin
        block_new[i*l3h_pkg::BYTE_W +: l3h_pkg::BYTE_W] = in_data_byte;
      end
    end
  end

  always_comb begin
    block_nxt        = block_r;
    fill_nxt         = fill_r;
    left_nxt         = left_r;
    push.valid       = 1'b0;
    push.entry.op    = l3h_pkg::OP_SEED;
    push.entry.w0    = block_new[31:0];
    push.entry.w1    = block_new[63:32];
    push.entry.w2    = block_new[95:64];
    if (accept && (in_cmd == l3h_pkg::CMD_START)) begin
      block_nxt     = '0;
      fill_nxt      = '0;
      left_nxt      = in_msg_length;
      push.valid    = 1'b1;
      push.entry.op = (in_msg_length == '0) ? l3h_pkg::OP_EMPTY : l3h_pkg::OP_SEED;
      push.entry.w0 = {{(l3h_pkg::WORD_W - l3h_pkg::LEN_W){1'b0}}, in_msg_length}
                      + l3h_pkg::SEED_CONST;
    end else if (byte_used) begin
      left_nxt = left_r - l3h_pkg::LEN_W'(1);
      if (last_byte || block_full) begin
        block_nxt     = '0;
        fill_nxt      = '0;
        push.valid    = 1'b1;
        push.entry.op = last_byte ? l3h_pkg::OP_FINAL : l3h_pkg::OP_MIX;
      end else begin
        block_nxt = block_new;
        fill_nxt  = fill_r + l3h_pkg::FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      left_r <= '0;
    end else begin
      fill_r <= fill_nxt;
      left_r <= left_nxt;
    end
    block_r <= block_nxt;
  end

endmodule

// ===== design/l3h_fifo.sv =====
`timescale 1ns / 1ps

module l3h_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  l3h_pkg::push_t      push,
  input  logic                pop,
  output logic                full,
  output l3h_pkg::fifo_stat_t stat
);

  l3h_pkg::op_entry_t           mem_r [l3h_pkg::FIFO_DEPTH];
  logic [l3h_pkg::FIFO_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [l3h_pkg::FIFO_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [l3h_pkg::FIFO_CW-1:0]  count_r, count_nxt;
  logic                         do_push;
  logic                         do_pop;

  assign full       = (count_r == l3h_pkg::FIFO_CW'(l3h_pkg::FIFO_DEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.head  = mem_r[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && !stat.empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + l3h_pkg::FIFO_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + l3h_pkg::FIFO_AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + l3h_pkg::FIFO_CW'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - l3h_pkg::FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end

endmodule

// ===== design/l3h_back.sv =====
`timescale 1ns / 1ps

module l3h_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  l3h_pkg::fifo_stat_t        stat,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [l3h_pkg::WORD_W-1:0] out_hash_high,
  output logic [l3h_pkg::WORD_W-1:0] out_hash_low
);

  l3h_pkg::state_t             state_r, state_nxt;
  logic [l3h_pkg::STEP_W-1:0]  step_r, step_nxt;
  l3h_pkg::lanes_t             lanes_r, lanes_nxt;
  l3h_pkg::lanes_t             mix_l, fin_l;
  logic                        out_valid_r, out_valid_nxt;
  logic [l3h_pkg::WORD_W-1:0]  high_r, high_nxt;
  logic [l3h_pkg::WORD_W-1:0]  low_r, low_nxt;
  logic                        out_free;
  logic                        fin_go;
  logic                        load;

  assign out_free = !out_valid_r || !out_stall;
  assign mix_l    = l3h_pkg::mix_step(lanes_r, step_r);
  assign fin_l    = l3h_pkg::fin_step(lanes_r, step_r);
  assign fin_go   = (step_r != l3h_pkg::FIN_LAST) || out_free;
  assign pop      = (state_r == l3h_pkg::ST_IDLE) && !stat.empty
                    && ((stat.head.op != l3h_pkg::OP_EMPTY) || out_free);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      l3h_pkg::ST_IDLE: begin
        if (pop && stat.head.op == l3h_pkg::OP_MIX) begin
          state_nxt = l3h_pkg::ST_MIX;
        end else if (pop && stat.head.op == l3h_pkg::OP_FINAL) begin
          state_nxt = l3h_pkg::ST_FIN;
        end
      end
      l3h_pkg::ST_MIX: begin
        if (step_r == l3h_pkg::MIX_LAST) begin
          state_nxt = l3h_pkg::ST_IDLE;
        end
      end
      l3h_pkg::ST_FIN: begin
        if (step_r == l3h_pkg::FIN_LAST && out_free) begin
          state_nxt = l3h_pkg::ST_IDLE;
        end
      end
      default: state_nxt = l3h_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    lanes_nxt = lanes_r;
    step_nxt  = step_r;
    load      = 1'b0;
    high_nxt  = high_r;
    low_nxt   = low_r;
    case (state_r)
      l3h_pkg::ST_IDLE: begin
        step_nxt = '0;
        if (pop) begin
          case (stat.head.op)
            l3h_pkg::OP_SEED: begin
              lanes_nxt.a = stat.head.w0;
              lanes_nxt.b = stat.head.w0;
              lanes_nxt.c = stat.head.w0;
            end
            l3h_pkg::OP_EMPTY: begin
              load     = 1'b1;
              high_nxt = stat.head.w0;
              low_nxt  = '0;
            end
            default: begin
              lanes_nxt.a = lanes_r.a + stat.head.w0;
              lanes_nxt.b = lanes_r.b + stat.head.w1;
              lanes_nxt.c = lanes_r.c + stat.head.w2;
            end
          endcase
        end
      end
      l3h_pkg::ST_MIX: begin
        lanes_nxt = mix_l;
        step_nxt  = step_r + l3h_pkg::STEP_W'(1);
      end
      l3h_pkg::ST_FIN: begin
        if (fin_go) begin
          lanes_nxt = fin_l;
          step_nxt  = step_r + l3h_pkg::STEP_W'(1);
          if (step_r == l3h_pkg::FIN_LAST) begin
            load     = 1'b1;
            high_nxt = fin_l.b;
            low_nxt  = fin_l.c;
          end
        end
      end
      default: begin
        step_nxt = '0;
      end
    endcase
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= l3h_pkg::ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      lanes_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      lanes_r     <= lanes_nxt;
    end
    high_r <= high_nxt;
    low_r  <= low_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_hash_high = high_r;
  assign out_hash_low  = low_r;

endmodule

// ===== design/lookup3_string_hash.sv =====
`timescale 1ns / 1ps
// Path: a start with length zero passes the queue and goes straight to the output register; the
// last byte of a message passes the queue, the block add, 7 final steps and the output register.
// Throughput: one byte per cycle within a message while in_stall is low; the shared lane unit
// works on one block or final mix at a time, so short messages are bounded by that unit.
// Reset (rst_n low, synchronous) empties the queue and clears the lanes and counters.

module lookup3_string_hash (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_cmd,
  input  logic [l3h_pkg::LEN_W-1:0]   in_msg_length,
  input  logic [l3h_pkg::BYTE_W-1:0]  in_data_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [l3h_pkg::WORD_W-1:0]  out_hash_high,
  output logic [l3h_pkg::WORD_W-1:0]  out_hash_low
);

  l3h_pkg::push_t      push;
  l3h_pkg::fifo_stat_t stat;
  logic                fifo_full;
  logic                pop;

  l3h_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_msg_length (in_msg_length),
    .in_data_byte  (in_data_byte),
    .fifo_full     (fifo_full),
    .push          (push)
  );

  l3h_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (fifo_full),
    .stat  (stat)
  );

  l3h_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .stat          (stat),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hash_high (out_hash_high),
    .out_hash_low  (out_hash_low)
  );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int LIMIT       = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_PAUSE = 20;

  typedef struct {
    logic [l3h_pkg::WORD_W-1:0] high;
    logic [l3h_pkg::WORD_W-1:0] low;
  } hash_t;

  typedef struct {
    logic                       cmd;
    logic [l3h_pkg::LEN_W-1:0]  len;
    logic [l3h_pkg::BYTE_W-1:0] data;
    bit                         typed;
    logic [l3h_pkg::WORD_W-1:0] high;
    logic [l3h_pkg::WORD_W-1:0] low;
  } row_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_cmd;
  logic [l3h_pkg::LEN_W-1:0]  in_msg_length;
  logic [l3h_pkg::BYTE_W-1:0] in_data_byte;
  logic                       out_valid;
  logic                       out_stall;
  logic [l3h_pkg::WORD_W-1:0] out_hash_high;
  logic [l3h_pkg::WORD_W-1:0] out_hash_low;

  logic [l3h_pkg::WORD_W-1:0] lane_a = '0;
  logic [l3h_pkg::WORD_W-1:0] lane_b = '0;
  logic [l3h_pkg::WORD_W-1:0] lane_c = '0;
  logic [l3h_pkg::BYTE_W-1:0] blk [l3h_pkg::BLOCK_SIZE];
  logic [l3h_pkg::LEN_W-1:0]  bytes_due = '0;
  int unsigned                fill_cnt = 0;

  hash_t hash_q[$];
  row_t  plan[$];

  int errors = 0;
  int cycles = 0;
  int tx_idle_pct = 38;
  int rx_idle_pct = 38;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int item_count = 0;

  lookup3_string_hash DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_msg_length (in_msg_length),
    .in_data_byte  (in_data_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hash_high (out_hash_high),
    .out_hash_low  (out_hash_low)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [l3h_pkg::WORD_W-1:0] rol32(input logic [l3h_pkg::WORD_W-1:0] x,
                                                       input int k);
    return (x << k) | (x >> (l3h_pkg::WORD_W - k));
  endfunction

  function automatic void clear_block();
    foreach (blk[i]) blk[i] = '0;
    fill_cnt = 0;
  endfunction

  function automatic bit predict_hash(input logic cmd, input logic [l3h_pkg::LEN_W-1:0] len,
                                      input logic [l3h_pkg::BYTE_W-1:0] data,
                                      output logic [l3h_pkg::WORD_W-1:0] high,
                                      output logic [l3h_pkg::WORD_W-1:0] low);
    logic [l3h_pkg::WORD_W-1:0] a, b, c;
    high = '0;
    low  = '0;
    if (cmd == l3h_pkg::CMD_START) begin
      lane_a    = {16'h0000, len} + l3h_pkg::SEED_CONST;
      lane_b    = lane_a;
      lane_c    = lane_a;
      bytes_due = len;
      clear_block();
      if (len == '0) begin
        high = lane_c;
        return 1'b1;
      end
      return 1'b0;
    end
    if (bytes_due == '0) return 1'b0;
    if (fill_cnt >= l3h_pkg::BLOCK_SIZE) fill_cnt = 0;
    blk[fill_cnt] = data;
    fill_cnt++;
    bytes_due--;
    if (bytes_due == '0 || fill_cnt == l3h_pkg::BLOCK_SIZE) begin
      a = lane_a + {blk[3], blk[2], blk[1], blk[0]};
      b = lane_b + {blk[7], blk[6], blk[5], blk[4]};
      c = lane_c + {blk[11], blk[10], blk[9], blk[8]};
      if (bytes_due == '0) begin
        c = (c ^ b) - rol32(b, 14);
        a = (a ^ c) - rol32(c, 11);
        b = (b ^ a) - rol32(a, 25);
        c = (c ^ b) - rol32(b, 16);
        a = (a ^ c) - rol32(c, 4);
        b = (b ^ a) - rol32(a, 14);
        c = (c ^ b) - rol32(b, 24);
      end else begin
        a = a - c; a = a ^ rol32(c, 4);  c = c + b;
        b = b - a; b = b ^ rol32(a, 6);  a = a + c;
        c = c - b; c = c ^ rol32(b, 8);  b = b + a;
        a = a - c; a = a ^ rol32(c, 16); c = c + b;
        b = b - a; b = b ^ rol32(a, 19); a = a + c;
        c = c - b; c = c ^ rol32(b, 4);  b = b + a;
      end
      lane_a = a;
      lane_b = b;
      lane_c = c;
      clear_block();
      if (bytes_due == '0) begin
        high = lane_b;
        low  = lane_c;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input logic [l3h_pkg::WORD_W-1:0] got,
                                 input logic [l3h_pkg::WORD_W-1:0] want);
    $display("MISMATCH %s: got %h, want %h (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  task automatic send_item(input logic cmd, input logic [l3h_pkg::LEN_W-1:0] len,
                           input logic [l3h_pkg::BYTE_W-1:0] data, input bit typed,
                           input logic [l3h_pkg::WORD_W-1:0] t_high,
                           input logic [l3h_pkg::WORD_W-1:0] t_low);
    bit                         has;
    logic [l3h_pkg::WORD_W-1:0] high, low;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_cmd        = cmd;
    in_msg_length = len;
    in_data_byte  = data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    has = predict_hash(cmd, len, data, high, low);
    if (typed) begin
      high = t_high;
      low  = t_low;
    end
    if (has) hash_q.push_back('{high, low});
  endtask

  task automatic send_message(input logic [l3h_pkg::LEN_W-1:0] len, input int n_bytes);
    send_item(l3h_pkg::CMD_START, len, l3h_pkg::BYTE_W'($urandom), 1'b0, '0, '0);
    for (int i = 0; i < n_bytes; i++) begin
      send_item(l3h_pkg::CMD_DATA, l3h_pkg::LEN_W'($urandom), l3h_pkg::BYTE_W'($urandom),
                1'b0, '0, '0);
    end
    item_count += 1 + n_bytes;
  endtask

  task automatic wait_drain();
    while (hash_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES - 1;
        out_stall = 1'b1;
      end else begin
        out_stall = ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    hash_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (hash_q.size() == 0) begin
        report_mismatch("unexpected transaction, hash_high", out_hash_high, '0);
      end else begin
        want = hash_q.pop_front();
        if (out_hash_high !== want.high) report_mismatch("hash_high", out_hash_high, want.high);
        if (out_hash_low !== want.low) report_mismatch("hash_low", out_hash_low, want.low);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int                        r;
    int                        n;
    logic [l3h_pkg::LEN_W-1:0] len;
    bit                        broken;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_cmd        = l3h_pkg::CMD_START;
    in_msg_length = '0;
    in_data_byte  = '0;
    clear_block();

    plan.push_back('{l3h_pkg::CMD_DATA,  16'hFFFF, 8'hFF, 1'b0, '0, '0});
    plan.push_back('{l3h_pkg::CMD_START, 16'h0000, 8'hFF, 1'b1, l3h_pkg::SEED_CONST, 32'h0});
    plan.push_back('{l3h_pkg::CMD_START, 16'hFFFF, 8'h00, 1'b0, '0, '0});
    plan.push_back('{l3h_pkg::CMD_DATA,  16'hFFFF, 8'h00, 1'b0, '0, '0});
    plan.push_back('{l3h_pkg::CMD_DATA,  16'h0000, 8'hFF, 1'b0, '0, '0});
    plan.push_back('{l3h_pkg::CMD_START, 16'h0000, 8'h00, 1'b1, l3h_pkg::SEED_CONST, 32'h0});
    plan.push_back('{l3h_pkg::CMD_START, 16'h0001, 8'h00, 1'b0, '0, '0});
    plan.push_back('{l3h_pkg::CMD_DATA,  16'h0000, 8'hFF, 1'b0, '0, '0});
    plan.push_back('{l3h_pkg::CMD_DATA,  16'h1234, 8'h5A, 1'b0, '0, '0});
    plan.push_back('{l3h_pkg::CMD_START, 16'h000C, 8'h77, 1'b0, '0, '0});
    plan.push_back('{l3h_pkg::CMD_DATA, 16'hFFFF, 8'h00, 1'b0, '0, '0});
    plan.push_back('{l3h_pkg::CMD_DATA, 16'h0000, 8'hFF, 1'b0, '0, '0});
    plan.push_back('{l3h_pkg::CMD_DATA, 16'hAAAA, 8'h01, 1'b0, '0, '0});
    plan.push_back('{l3h_pkg::CMD_DATA, 16'h5555, 8'h80, 1'b0, '0, '0});
    plan.push_back('{l3h_pkg::CMD_DATA, 16'h0F0F, 8'h7F, 1'b0, '0, '0});
    plan.push_back('{l3h_pkg::CMD_DATA, 16'hF0F0, 8'hFE, 1'b0, '0, '0});
    plan.push_back('{l3h_pkg::CMD_DATA, 16'h0001, 8'h10, 1'b0, '0, '0});
    plan.push_back('{l3h_pkg::CMD_DATA, 16'h8000, 8'h20, 1'b0, '0, '0});
    plan.push_back('{l3h_pkg::CMD_DATA, 16'h00FF, 8'hC3, 1'b0, '0, '0});
    plan.push_back('{l3h_pkg::CMD_DATA, 16'hFF00, 8'h3C, 1'b0, '0, '0});
    plan.push_back('{l3h_pkg::CMD_DATA, 16'h1111, 8'hAA, 1'b0, '0, '0});
    plan.push_back('{l3h_pkg::CMD_DATA, 16'h2222, 8'h55, 1'b0, '0, '0});
    plan.push_back('{l3h_pkg::CMD_DATA, 16'h3333, 8'h99, 1'b0, '0, '0});

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      send_item(plan[i].cmd, plan[i].len, plan[i].data, plan[i].typed,
                plan[i].high, plan[i].low);
    end

    while (item_count < 700) begin
      if (item_count >= 250 && item_count < 400) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = 38;
        rx_idle_pct = 38;
      end

      if (item_count >= 400 && hold_req == 0) begin
        hold_req = 1;
        for (int k = 0; k < 24; k++) send_message(l3h_pkg::LEN_W'(k % 2), k % 2);
        @(negedge clk);
        in_valid = 1'b0;
        wait_drain();
      end

      r      = $urandom_range(99);
      broken = ($urandom_range(99) < 10);
      if (r < 12)      len = '0;
      else if (r < 22) len = l3h_pkg::LEN_W'(12 * $urandom_range(1, 4));
      else if (r < 26) len = l3h_pkg::LEN_W'($urandom_range(100, 250));
      else             len = l3h_pkg::LEN_W'($urandom_range(1, 30));
      if (broken && $urandom_range(1) == 1) len = l3h_pkg::LEN_W'($urandom);
      n = len;
      if (broken && len > 0) n = $urandom_range(0, (len > 20) ? 20 : len - 1);
      send_message(len, n);
      if (!broken && $urandom_range(99) < 8) begin
        send_item(l3h_pkg::CMD_DATA, l3h_pkg::LEN_W'($urandom), l3h_pkg::BYTE_W'($urandom),
                  1'b0, '0, '0);
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    wait_drain();
    repeat (DRAIN_PAUSE) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
